// ===== src/sss_pkg.sv =====
// shared types and constants for the segmented stack set
package sss_pkg;

    // fixed field widths
    localparam int DATA_W   = 32;
    localparam int OP_W     = 2;
    localparam int TGT_W    = 3;
    localparam int STATUS_W = 2;
    localparam int LAST_W   = 3;
    localparam int CAP_W    = 4;

    // stream widths
    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 40;
    localparam int M_TUSER_W = 3;

    // capacity after reset
    localparam logic [CAP_W-1:0] CAP_RESET = 4'd5;

    // operation codes
    localparam logic [OP_W-1:0] OP_PUSH   = 2'd0;
    localparam logic [OP_W-1:0] OP_POP    = 2'd1;
    localparam logic [OP_W-1:0] OP_POP_AT = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_PUSH_CHK,
        S_PUSH_NEW,
        S_POP,
        S_SHIFT,
        S_TOP,
        S_RESP
    } state_t;

endpackage

// ===== src/sss_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
module sss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                    aclk,
    input  logic                                    wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                        wr_data,
    input  logic                                    rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                        rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read, held while rd_en is low
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== src/segmented_stack_set.sv =====
// top level of the segmented stack set
//
// One stack built from up to MAX_STACKS sub-stacks of at most plate_capacity
// values each (clamped to 1..PLATE_DEPTH). Each input beat carries one
// operation (push, pop from the last sub-stack, pop from a chosen sub-stack)
// and yields exactly one result beat with status, top value, top_valid and
// last sub-stack position. A small sequencer handles one beat at a time and
// s_tready is low while it works. A pop on an empty set, a pop-at beyond
// the last sub-stack or an unused operation goes straight to the top read;
// a push that opens the first sub-stack writes in S_PUSH_NEW, other pushes
// pass S_PUSH_CHK and then S_PUSH_NEW if they must open a further sub-stack;
// pops pass S_POP, and a pop that empties its sub-stack also passes S_SHIFT,
// where the sub-stack order is shifted down one entry per cycle from that
// position to the end.
// The result sits in an output register, so a held result stalls the next
// beat only at its final cycle. Values live in a MAX_STACKS*PLATE_DEPTH ram
// with one write and one registered read port; no clearing pass is needed.
module segmented_stack_set #(
    parameter int MAX_STACKS  = 8,
    parameter int PLATE_DEPTH = 8,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // configuration: plate_capacity
    input  logic                             cfg_we,
    input  logic [sss_pkg::CAP_W-1:0]        cfg_wdata,
    // input beats
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [sss_pkg::S_TDATA_W-1:0]    s_tdata,  // push_value[31:0], target_stack[34:32]
    input  logic [sss_pkg::S_TUSER_W-1:0]    s_tuser,  // op[1:0]
    // result beats
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [sss_pkg::M_TDATA_W-1:0]    m_tdata,  // top_value[31:0], last_stack[34:32]
    output logic [sss_pkg::M_TUSER_W-1:0]    m_tuser   // status[1:0], top_valid[2]
);

    localparam int SLOT_W  = $clog2(MAX_STACKS);
    localparam int CNT_W   = $clog2(MAX_STACKS + 1);
    localparam int FILL_W  = $clog2(PLATE_DEPTH + 1);
    localparam int STORE_W = (VALUE_WIDTH < sss_pkg::DATA_W) ? VALUE_WIDTH : sss_pkg::DATA_W;
    localparam int DEPTH   = MAX_STACKS * PLATE_DEPTH;
    localparam int ADDR_W  = $clog2(DEPTH);

    // control state
    sss_pkg::state_t state_reg, state_next;
    logic [sss_pkg::CAP_W-1:0] cap_reg, cap_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [FILL_W-1:0] fill_reg [MAX_STACKS];
    logic [FILL_W-1:0] fill_next [MAX_STACKS];
    logic [SLOT_W-1:0] order_reg [MAX_STACKS];
    logic [SLOT_W-1:0] order_next [MAX_STACKS];
    logic m_valid_reg, m_valid_next;

    // working registers of the current beat
    logic [sss_pkg::OP_W-1:0] op_reg, op_next;
    logic [STORE_W-1:0] val_reg, val_next;
    logic [sss_pkg::TGT_W-1:0] tgt_reg, tgt_next;
    logic [SLOT_W-1:0] pos_reg, pos_next;
    logic [SLOT_W-1:0] phys_reg, phys_next;
    logic [sss_pkg::STATUS_W-1:0] status_reg, status_next;
    logic has_top_reg, has_top_next;

    // result registers
    logic [sss_pkg::STATUS_W-1:0] m_status_reg, m_status_next;
    logic [sss_pkg::DATA_W-1:0] m_top_reg, m_top_next;
    logic m_topv_reg, m_topv_next;
    logic [sss_pkg::LAST_W-1:0] m_last_reg, m_last_next;

    // ram ports
    logic ram_wr_en;
    logic [ADDR_W-1:0] ram_wr_addr;
    logic ram_rd_en;
    logic [ADDR_W-1:0] ram_rd_addr;
    logic [STORE_W-1:0] ram_rd_data;

    // shared lookups
    logic [SLOT_W-1:0] last_pos;
    logic [SLOT_W-1:0] cnt_slot;
    logic [SLOT_W-1:0] shift_src;
    logic shift_last;
    logic [FILL_W-1:0] cap_eff;
    logic [SLOT_W-1:0] order_rd_addr;
    logic [SLOT_W-1:0] order_rd;
    logic [SLOT_W-1:0] fill_rd_addr;
    logic [FILL_W-1:0] fill_rd;
    logic [FILL_W-1:0] fill_dec;
    logic out_free;

    function automatic logic [ADDR_W-1:0] ram_addr(input logic [SLOT_W-1:0] slot,
                                                   input logic [FILL_W-1:0] idx);
        ram_addr = ADDR_W'(slot) * ADDR_W'(PLATE_DEPTH) + ADDR_W'(idx);
    endfunction

    sss_ram #(
        .WIDTH (STORE_W),
        .DEPTH (DEPTH)
    ) u_value_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (val_reg),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // positions and capacity
    assign last_pos   = SLOT_W'(count_reg - 1'b1);
    assign cnt_slot   = SLOT_W'(count_reg);
    assign shift_last = (32'(pos_reg) + 1 >= MAX_STACKS);
    assign shift_src  = shift_last ? pos_reg : SLOT_W'(pos_reg + 1'b1);
    assign out_free   = !m_valid_reg || m_tready;

    always_comb begin
        if (cap_reg == '0) begin
            cap_eff = FILL_W'(1);
        end else if (32'(cap_reg) > PLATE_DEPTH) begin
            cap_eff = FILL_W'(PLATE_DEPTH);
        end else begin
            cap_eff = FILL_W'(cap_reg);
        end
    end

    // order table read address
    always_comb begin
        unique case (state_reg)
            sss_pkg::S_LOOK: begin
                if (op_reg == sss_pkg::OP_POP_AT) begin
                    order_rd_addr = SLOT_W'(tgt_reg);
                end else begin
                    order_rd_addr = last_pos;
                end
            end
            sss_pkg::S_PUSH_NEW: order_rd_addr = cnt_slot;
            sss_pkg::S_SHIFT:    order_rd_addr = shift_src;
            sss_pkg::S_TOP:      order_rd_addr = last_pos;
            default:             order_rd_addr = '0;
        endcase
    end

    assign order_rd     = order_reg[order_rd_addr];
    assign fill_rd_addr = (state_reg == sss_pkg::S_TOP) ? order_rd : phys_reg;
    assign fill_rd      = fill_reg[fill_rd_addr];
    assign fill_dec     = (fill_rd != '0) ? fill_rd - 1'b1 : '0;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            sss_pkg::S_IDLE: begin
                if (s_tvalid) begin
                    state_next = sss_pkg::S_LOOK;
                end
            end
            sss_pkg::S_LOOK: begin
                unique case (op_reg)
                    sss_pkg::OP_PUSH: begin
                        state_next = (count_reg == '0) ? sss_pkg::S_PUSH_NEW
                                                       : sss_pkg::S_PUSH_CHK;
                    end
                    sss_pkg::OP_POP: begin
                        state_next = (count_reg == '0) ? sss_pkg::S_TOP : sss_pkg::S_POP;
                    end
                    sss_pkg::OP_POP_AT: begin
                        if (count_reg == '0 || tgt_reg >= count_reg) begin
                            state_next = sss_pkg::S_TOP;
                        end else begin
                            state_next = sss_pkg::S_POP;
                        end
                    end
                    default: state_next = sss_pkg::S_TOP;
                endcase
            end
            sss_pkg::S_PUSH_CHK: begin
                if (fill_rd < cap_eff || 32'(count_reg) >= MAX_STACKS) begin
                    state_next = sss_pkg::S_TOP;
                end else begin
                    state_next = sss_pkg::S_PUSH_NEW;
                end
            end
            sss_pkg::S_PUSH_NEW: state_next = sss_pkg::S_TOP;
            sss_pkg::S_POP: begin
                state_next = (fill_dec == '0) ? sss_pkg::S_SHIFT : sss_pkg::S_TOP;
            end
            sss_pkg::S_SHIFT: begin
                if (shift_last) begin
                    state_next = sss_pkg::S_TOP;
                end
            end
            sss_pkg::S_TOP: state_next = sss_pkg::S_RESP;
            sss_pkg::S_RESP: begin
                if (out_free) begin
                    state_next = sss_pkg::S_IDLE;
                end
            end
            default: state_next = sss_pkg::S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        cap_next      = cfg_we ? cfg_wdata : cap_reg;
        count_next    = count_reg;
        fill_next     = fill_reg;
        order_next    = order_reg;
        op_next       = op_reg;
        val_next      = val_reg;
        tgt_next      = tgt_reg;
        pos_next      = pos_reg;
        phys_next     = phys_reg;
        status_next   = status_reg;
        has_top_next  = has_top_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_status_next = m_status_reg;
        m_top_next    = m_top_reg;
        m_topv_next   = m_topv_reg;
        m_last_next   = m_last_reg;
        ram_wr_en     = 1'b0;
        ram_wr_addr   = ram_addr(phys_reg, fill_rd);
        ram_rd_en     = 1'b0;
        ram_rd_addr   = ram_addr(order_rd, fill_dec);
        s_tready      = 1'b0;

        unique case (state_reg)
            // take one beat
            sss_pkg::S_IDLE: begin
                s_tready = 1'b1;
                op_next  = s_tuser[sss_pkg::OP_W-1:0];
                val_next = s_tdata[STORE_W-1:0];
                tgt_next = s_tdata[sss_pkg::DATA_W +: sss_pkg::TGT_W];
            end
            // locate the sub-stack and check for errors
            sss_pkg::S_LOOK: begin
                pos_next    = order_rd_addr;
                phys_next   = order_rd;
                status_next = sss_pkg::ST_OK;
                if ((op_reg == sss_pkg::OP_POP || op_reg == sss_pkg::OP_POP_AT)
                    && count_reg == '0) begin
                    status_next = sss_pkg::ST_EMPTY;
                end else if (op_reg == sss_pkg::OP_POP_AT && tgt_reg >= count_reg) begin
                    status_next = sss_pkg::ST_RANGE;
                end
            end
            // push onto the last sub-stack if it has room
            sss_pkg::S_PUSH_CHK: begin
                if (fill_rd < cap_eff) begin
                    ram_wr_en           = 1'b1;
                    fill_next[phys_reg] = fill_rd + 1'b1;
                end else if (32'(count_reg) >= MAX_STACKS) begin
                    status_next = sss_pkg::ST_FULL;
                end
            end
            // open a new sub-stack and push its first value
            sss_pkg::S_PUSH_NEW: begin
                ram_wr_en           = 1'b1;
                ram_wr_addr         = ram_addr(order_rd, '0);
                fill_next[order_rd] = FILL_W'(1);
                count_next          = count_reg + 1'b1;
            end
            // drop the top value of the chosen sub-stack
            sss_pkg::S_POP: begin
                fill_next[phys_reg] = fill_dec;
            end
            // move later sub-stacks down, freed slot goes to the end
            sss_pkg::S_SHIFT: begin
                order_next[pos_reg] = shift_last ? phys_reg : order_rd;
                if (shift_last) begin
                    if (count_reg != '0) begin
                        count_next = count_reg - 1'b1;
                    end
                end else begin
                    pos_next = shift_src;
                end
            end
            // read the top of the last sub-stack
            sss_pkg::S_TOP: begin
                has_top_next = (count_reg != '0) && (fill_rd != '0);
                ram_rd_en    = has_top_next;
            end
            // load the result register
            sss_pkg::S_RESP: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = status_reg;
                    m_top_next    = has_top_reg ? sss_pkg::DATA_W'(ram_rd_data) : '0;
                    m_topv_next   = (count_reg != '0);
                    m_last_next   = (count_reg != '0)
                                    ? sss_pkg::LAST_W'(count_reg - 1'b1) : '0;
                end
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= sss_pkg::S_IDLE;
            cap_reg     <= sss_pkg::CAP_RESET;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_STACKS; i++) begin
                fill_reg[i]  <= '0;
                order_reg[i] <= SLOT_W'(i);
            end
        end else begin
            state_reg   <= state_next;
            cap_reg     <= cap_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
            fill_reg    <= fill_next;
            order_reg   <= order_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        val_reg      <= val_next;
        tgt_reg      <= tgt_next;
        pos_reg      <= pos_next;
        phys_reg     <= phys_next;
        status_reg   <= status_next;
        has_top_reg  <= has_top_next;
        m_status_reg <= m_status_next;
        m_top_reg    <= m_top_next;
        m_topv_reg   <= m_topv_next;
        m_last_reg   <= m_last_next;
    end

    // result beat
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(sss_pkg::M_TDATA_W - sss_pkg::DATA_W - sss_pkg::LAST_W)'(0),
                       m_last_reg, m_top_reg};
    assign m_tuser  = {m_topv_reg, m_status_reg};

endmodule

// ===== src/sss_checker.sv =====
// port-level checks for the segmented stack set, bound to the top level
module sss_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [sss_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [sss_pkg::M_TUSER_W-1:0] m_tuser
);

    // a stalled result beat holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // one beat at a time: not ready right after an accepted beat
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while a beat is in progress");

    // empty stack reports zero top and zero position
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[2] |-> m_tdata[sss_pkg::DATA_W+sss_pkg::LAST_W-1:0] == '0)
        else $error("empty stack with nonzero top or position");

    // pop on empty leaves nothing held, range and full errors need values held
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser[1:0] == sss_pkg::ST_EMPTY && !m_tuser[2])
                  || (m_tuser[1:0] == sss_pkg::ST_RANGE && m_tuser[2])
                  || (m_tuser[1:0] == sss_pkg::ST_FULL && m_tuser[2])
                  || (m_tuser[1:0] == sss_pkg::ST_OK))
        else $error("status inconsistent with top_valid");

endmodule

bind segmented_stack_set sss_checker u_sss_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== bench/stack_result_checker.sv =====
// checker that predicts and compares the result beats of the segmented stack set
module stack_result_checker #(
    parameter int MAX_STACKS  = 8,
    parameter int PLATE_DEPTH = 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [sss_pkg::CAP_W-1:0]     cfg_wdata,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [sss_pkg::S_TDATA_W-1:0] s_tdata,   // push_value[31:0], target_stack[34:32]
    input  logic [sss_pkg::S_TUSER_W-1:0] s_tuser,   // op[1:0]
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [sss_pkg::M_TDATA_W-1:0] m_tdata,   // top_value[31:0], last_stack[34:32]
    input  logic [sss_pkg::M_TUSER_W-1:0] m_tuser,   // status[1:0], top_valid[2]
    output int                            fail_count,
    output int                            open_count
);

    // one result beat, as predicted or as seen
    typedef struct packed {
        logic [sss_pkg::STATUS_W-1:0] status;
        logic [sss_pkg::DATA_W-1:0]   top_value;
        logic                         top_valid;
        logic [sss_pkg::LAST_W-1:0]   last_stack;
    } stack_reply_t;

    // shadow copy of the stack set
    logic [sss_pkg::DATA_W-1:0] plate_mem [MAX_STACKS][PLATE_DEPTH];
    int unsigned                plate_fill [MAX_STACKS];
    int unsigned                plate_order [MAX_STACKS];
    int unsigned                plates_used;
    logic [sss_pkg::CAP_W-1:0]  capacity;

    stack_reply_t predicted_replies [$];
    int           fails;

    // capacity as the block applies it, clamped to 1..PLATE_DEPTH
    function automatic int unsigned plate_limit();
        int unsigned c;
        c = capacity;
        if (c < 1) c = 1;
        if (c > PLATE_DEPTH) c = PLATE_DEPTH;
        return c;
    endfunction

    // take the top value off the sub-stack at pos, removing it once emptied
    function automatic void take_top(int unsigned pos);
        int unsigned phys;
        phys = plate_order[pos];
        if (plate_fill[phys] > 0) plate_fill[phys]--;
        if (plate_fill[phys] == 0) begin
            for (int unsigned i = pos; i + 1 < MAX_STACKS; i++) begin
                plate_order[i] = plate_order[i + 1];
            end
            plate_order[MAX_STACKS - 1] = phys;
            if (plates_used > 0) plates_used--;
        end
    endfunction

    // apply one operation to the shadow state and return the reply it causes
    function automatic stack_reply_t apply_stack_op(
        input logic [sss_pkg::OP_W-1:0]   op,
        input logic [sss_pkg::DATA_W-1:0] value,
        input logic [sss_pkg::TGT_W-1:0]  target);
        stack_reply_t r;
        bit           room;
        int unsigned  phys;
        int unsigned  f;
        r.status = sss_pkg::ST_OK;
        phys = 0;
        case (op)
            sss_pkg::OP_PUSH: begin
                room = 1'b0;
                if (plates_used > 0) begin
                    phys = plate_order[plates_used - 1];
                    room = plate_fill[phys] < plate_limit();
                end
                // last sub-stack full: open a new one if any slot is left
                if (!room) begin
                    if (plates_used < MAX_STACKS) begin
                        phys = plate_order[plates_used];
                        plate_fill[phys] = 0;
                        plates_used++;
                        room = 1'b1;
                    end else begin
                        r.status = sss_pkg::ST_FULL;
                    end
                end
                if (room) begin
                    f = plate_fill[phys];
                    if (f < PLATE_DEPTH) begin
                        plate_mem[phys][f] = value;
                        plate_fill[phys] = f + 1;
                    end
                end
            end
            sss_pkg::OP_POP: begin
                if (plates_used == 0) r.status = sss_pkg::ST_EMPTY;
                else take_top(plates_used - 1);
            end
            sss_pkg::OP_POP_AT: begin
                if (plates_used == 0) r.status = sss_pkg::ST_EMPTY;
                else if (target >= plates_used) r.status = sss_pkg::ST_RANGE;
                else take_top(target);
            end
            default: begin
            end
        endcase
        // report the top of the last sub-stack
        if (plates_used > 0) begin
            phys = plate_order[plates_used - 1];
            f = plate_fill[phys];
            if (f > PLATE_DEPTH) f = PLATE_DEPTH;
            r.top_value  = (f > 0) ? plate_mem[phys][f - 1] : '0;
            r.top_valid  = 1'b1;
            r.last_stack = sss_pkg::LAST_W'(plates_used - 1);
        end else begin
            r.top_value  = '0;
            r.top_valid  = 1'b0;
            r.last_stack = '0;
        end
        return r;
    endfunction

    // track config writes, input beats and result beats
    always @(posedge aclk) begin : track
        stack_reply_t want;
        stack_reply_t got;
        if (!aresetn) begin
            for (int i = 0; i < MAX_STACKS; i++) begin
                plate_fill[i]  = 0;
                plate_order[i] = i;
            end
            plates_used = 0;
            capacity = sss_pkg::CAP_RESET;
            predicted_replies.delete();
        end else begin
            if (cfg_we) capacity = cfg_wdata;
            // result beat against the oldest prediction
            if (m_tvalid && m_tready) begin
                got.status     = m_tuser[sss_pkg::STATUS_W-1:0];
                got.top_valid  = m_tuser[sss_pkg::STATUS_W];
                got.top_value  = m_tdata[sss_pkg::DATA_W-1:0];
                got.last_stack = m_tdata[sss_pkg::DATA_W +: sss_pkg::LAST_W];
                if (predicted_replies.size() == 0) begin
                    $error("result beat with no prediction waiting");
                    fails++;
                end else begin
                    want = predicted_replies.pop_front();
                    if (got.status !== want.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, got.status);
                        fails++;
                    end
                    if (got.top_value !== want.top_value) begin
                        $error("top_value mismatch: expected %h, actual %h",
                               want.top_value, got.top_value);
                        fails++;
                    end
                    if (got.top_valid !== want.top_valid) begin
                        $error("top_valid mismatch: expected %0d, actual %0d",
                               want.top_valid, got.top_valid);
                        fails++;
                    end
                    if (got.last_stack !== want.last_stack) begin
                        $error("last_stack mismatch: expected %0d, actual %0d",
                               want.last_stack, got.last_stack);
                        fails++;
                    end
                end
            end
            // input beat: predict its reply and append it
            if (s_tvalid && s_tready) begin
                predicted_replies.insert(predicted_replies.size(),
                    apply_stack_op(s_tuser[sss_pkg::OP_W-1:0],
                                   s_tdata[sss_pkg::DATA_W-1:0],
                                   s_tdata[sss_pkg::DATA_W +: sss_pkg::TGT_W]));
            end
        end
        fail_count <= fails;
        open_count <= predicted_replies.size();
    end

endmodule

// ===== bench/tb_top.sv =====
// stimulus, clocking and verdict for the segmented stack set
module tb_top;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 32;
    localparam int PHASE_BEATS    = 100;
    localparam int RANDOM_PHASES  = 7;
    localparam logic [sss_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

    logic                          aclk;
    logic                          aresetn;
    logic                          cfg_we;
    logic [sss_pkg::CAP_W-1:0]     cfg_wdata;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [sss_pkg::S_TDATA_W-1:0] s_tdata;   // push_value[31:0], target_stack[34:32]
    logic [sss_pkg::S_TUSER_W-1:0] s_tuser;   // op[1:0]
    logic                          m_tvalid;
    logic                          m_tready;
    logic [sss_pkg::M_TDATA_W-1:0] m_tdata;   // top_value[31:0], last_stack[34:32]
    logic [sss_pkg::M_TUSER_W-1:0] m_tuser;   // status[1:0], top_valid[2]

    int fail_count;
    int open_count;
    int stall_mode;
    int stall_phase;
    int quiet_cycles;

    segmented_stack_set u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    stack_result_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .open_count (open_count)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // receiver stall pattern
    always @(posedge aclk) begin
        stall_phase <= (stall_phase + 1) % 9;
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 3) != 0);
            2: m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= (stall_phase >= 5);
        endcase
    end

    // watchdog on cycles without any accepted beat
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("segmented_stack_set test failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // offer one beat and hold it until accepted
    task automatic send_beat(input logic [sss_pkg::OP_W-1:0]   op,
                             input logic [sss_pkg::DATA_W-1:0] value,
                             input logic [sss_pkg::TGT_W-1:0]  target);
        s_tvalid <= 1'b1;
        s_tdata  <= sss_pkg::S_TDATA_W'({target, value});
        s_tuser  <= sss_pkg::S_TUSER_W'(op);
        do @(posedge aclk); while (!s_tready);
    endtask

    // let the block drain completely
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (open_count != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // write plate_capacity while idle
    task automatic set_capacity(input logic [sss_pkg::CAP_W-1:0] cap);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= cap;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    initial begin : stimulus
        logic [sss_pkg::CAP_W-1:0] phase_caps [RANDOM_PHASES];
        logic [sss_pkg::OP_W-1:0]  op;
        int                        push_pct;
        int                        burst_left;
        int                        roll;
        bit                        no_gaps;

        aresetn     = 1'b0;
        cfg_we      = 1'b0;
        cfg_wdata   = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        stall_mode  = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty set, value extremes, range and unused op at reset capacity
        send_beat(sss_pkg::OP_POP, 32'h0, 3'd0);
        send_beat(sss_pkg::OP_POP_AT, 32'h0, 3'd7);
        send_beat(OP_UNUSED, 32'hFFFF_FFFF, 3'd7);
        send_beat(sss_pkg::OP_PUSH, 32'h7FFF_FFFF, 3'd0);
        send_beat(sss_pkg::OP_PUSH, 32'h8000_0000, 3'd7);
        send_beat(sss_pkg::OP_PUSH, 32'h0000_0000, 3'd0);
        send_beat(sss_pkg::OP_PUSH, 32'hFFFF_FFFF, 3'd0);
        send_beat(sss_pkg::OP_POP_AT, 32'h0, 3'd1);
        send_beat(sss_pkg::OP_POP_AT, 32'h0, 3'd0);
        send_beat(sss_pkg::OP_POP, 32'h0, 3'd0);

        // capacity one: fill all sub-stacks, overflow, remove from the middle
        set_capacity(4'd1);
        stall_mode = 1;
        for (int i = 0; i < 8; i++) send_beat(sss_pkg::OP_PUSH, $urandom(), 3'(i));
        send_beat(sss_pkg::OP_PUSH, 32'h1234_5678, 3'd0);
        send_beat(sss_pkg::OP_POP_AT, 32'h0, 3'd3);
        send_beat(sss_pkg::OP_POP_AT, 32'h0, 3'd0);
        send_beat(sss_pkg::OP_POP_AT, 32'h0, 3'd7);

        // capacity lowered below the fill of the last sub-stack
        set_capacity(4'd8);
        for (int i = 0; i < 3; i++) send_beat(sss_pkg::OP_PUSH, $urandom(), 3'd0);
        set_capacity(4'd2);
        send_beat(sss_pkg::OP_PUSH, 32'h5555_AAAA, 3'd0);
        send_beat(sss_pkg::OP_POP, 32'h0, 3'd0);
        send_beat(sss_pkg::OP_POP, 32'h0, 3'd0);

        // random phases, extremes of the capacity first
        phase_caps[0] = 4'd0;
        phase_caps[1] = 4'd15;
        phase_caps[2] = 4'd8;
        phase_caps[3] = 4'd1;
        for (int p = 4; p < RANDOM_PHASES; p++) begin
            phase_caps[p] = sss_pkg::CAP_W'($urandom_range(0, 15));
        end

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            set_capacity(phase_caps[p]);
            stall_mode = $urandom_range(0, 3);
            no_gaps    = (p % 3 == 0);
            case (p % 3)
                0: push_pct = 70;
                1: push_pct = 50;
                default: push_pct = 40;
            endcase
            burst_left = $urandom_range(1, 20);
            for (int n = 0; n < PHASE_BEATS; n++) begin
                // sender gap between bursts
                if (burst_left == 0) begin
                    if (!no_gaps) begin
                        s_tvalid <= 1'b0;
                        repeat ($urandom_range(1, 8)) @(posedge aclk);
                    end
                    burst_left = $urandom_range(1, 20);
                end
                burst_left--;
                roll = $urandom_range(0, 99);
                if (roll < push_pct) op = sss_pkg::OP_PUSH;
                else if (roll >= 95) op = OP_UNUSED;
                else if (roll[0]) op = sss_pkg::OP_POP;
                else op = sss_pkg::OP_POP_AT;
                send_beat(op, $urandom(), sss_pkg::TGT_W'($urandom_range(0, 7)));
            end
        end

        // drain and verdict
        wait_drained();
        if (fail_count == 0 && open_count == 0) begin
            $display("segmented_stack_set test passed");
        end else begin
            $display("segmented_stack_set test failed");
        end
        $finish;
    end

endmodule
